@@ rtl/mheq_pkg.sv @@
// ----------------------------------------------------------------------------
// mheq_pkg: shared constants of the min-heap event queue
// Holds default sizes, request modes and status codes.
// ----------------------------------------------------------------------------
package mheq_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int KEY_BITS_DEF   = 48;
  localparam int COORD_BITS_DEF = 16;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

@@ rtl/min_heap_event_queue_top.sv @@
// ----------------------------------------------------------------------------
// min_heap_event_queue_top: binary min-heap priority queue of timed events
// One request at a time; each sift level is a memory read followed by a
// compare/write, and the root is re-read for the ready flag.
// Reset clears the state, the entry count and done; the entry memory needs no clearing.
// The result strobe lasts one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module min_heap_event_queue_top #(
  parameter int CAPACITY   = mheq_pkg::CAPACITY_DEF,
  parameter int KEY_BITS   = mheq_pkg::KEY_BITS_DEF,
  parameter int COORD_BITS = mheq_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  mode,
  input  logic [KEY_BITS-1:0]         event_moment,
  input  logic [COORD_BITS-1:0]       event_x,
  input  logic [COORD_BITS-1:0]       event_y,
  input  logic [KEY_BITS-1:0]         now,
  output logic                        done,
  output logic                        popped_valid,
  output logic [KEY_BITS-1:0]         out_moment,
  output logic [COORD_BITS-1:0]       out_x,
  output logic [COORD_BITS-1:0]       out_y,
  output logic [1:0]                  status,
  output logic [$clog2(CAPACITY+1)-1:0] occupancy,
  output logic                        ready_res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY+1);
  localparam int EW = KEY_BITS + 2*COORD_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_POP_RD, S_POP_MV, S_DN_RD, S_DN_CMP,
    S_RT_RD, S_RT_CMP
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [AW-1:0]   pos;
  logic [EW-1:0]   cur;      // entry being sifted
  logic [KEY_BITS-1:0] now_q;

  logic            we;
  logic [AW-1:0]   waddr, ra, rb;
  logic [EW-1:0]   wdata, rda, rdb;

  mheq_store #(.CAPACITY(CAPACITY), .WIDTH(EW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(ra), .raddr_b(rb), .rdata_a(rda), .rdata_b(rdb)
  );

  // child addresses, widened so overflow past the count is visible
  logic [AW+1:0] left_w, right_w;
  logic          has_l, has_r, pick_r, dn_swap, up_swap;
  logic [AW-1:0] parent, pick_a;
  logic [EW-1:0] pick_e;

  assign left_w  = {1'b0, pos, 1'b1};
  assign right_w = left_w + (AW+2)'(1);
  assign has_l   = left_w  < (AW+2)'(count);
  assign has_r   = right_w < (AW+2)'(count);
  assign parent  = AW'((pos - AW'(1)) >> 1);
  assign pick_r  = has_r && (rda[KEY_BITS-1:0] > rdb[KEY_BITS-1:0]);
  assign pick_e  = pick_r ? rdb : rda;
  assign pick_a  = pick_r ? right_w[AW-1:0] : left_w[AW-1:0];
  assign dn_swap = cur[KEY_BITS-1:0] > pick_e[KEY_BITS-1:0];
  assign up_swap = rda[KEY_BITS-1:0] > cur[KEY_BITS-1:0];

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = cur;
    ra    = pos;
    rb    = pos;
    case (state)
      S_IDLE: begin
        ra = '0;
        rb = AW'(count - CW'(1));
        if (start && mode == mheq_pkg::MODE_INSERT && count < CW'(CAPACITY)) begin
          we    = 1'b1;
          waddr = AW'(count);
          wdata = {event_y, event_x, event_moment};
        end
      end
      S_UP_RD: begin
        ra = parent;
        // place the entry once it has climbed to the root
        if (pos == '0) begin
          we = 1'b1;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (up_swap) begin
          wdata = rda;
        end
      end
      S_DN_RD: begin
        ra = left_w[AW-1:0];
        rb = right_w[AW-1:0];
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (has_l && dn_swap) begin
          wdata = pick_e;
        end
      end
      S_RT_RD: ra = '0;
      default: ;
    endcase
  end

  assign busy      = state != S_IDLE;
  assign occupancy = count;

  // control sequence and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            now_q        <= now;
            popped_valid <= 1'b0;
            out_moment   <= '0;
            out_x        <= '0;
            out_y        <= '0;
            status       <= mheq_pkg::ST_OK;
            state        <= S_RT_RD;
            if (mode == mheq_pkg::MODE_INSERT) begin
              if (count < CW'(CAPACITY)) begin
                cur   <= {event_y, event_x, event_moment};
                pos   <= AW'(count);
                count <= count + CW'(1);
                state <= S_UP_RD;
              end else begin
                status <= mheq_pkg::ST_FULL;
              end
            end else if (mode == mheq_pkg::MODE_POP) begin
              if (count == '0) begin
                status <= mheq_pkg::ST_EMPTY;
              end else begin
                count <= count - CW'(1);
                state <= S_POP_RD;
              end
            end
          end
        end
        S_UP_RD: state <= (pos == '0) ? S_RT_RD : S_UP_CMP;
        S_UP_CMP: begin
          // move the parent down on swap, else place the entry here
          if (up_swap) begin
            pos   <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_RT_RD;
          end
        end
        S_POP_RD: begin
          popped_valid <= 1'b1;
          out_moment   <= rda[KEY_BITS-1:0];
          out_x        <= rda[KEY_BITS +: COORD_BITS];
          out_y        <= rda[KEY_BITS+COORD_BITS +: COORD_BITS];
          cur          <= rdb;
          pos          <= '0;
          state        <= S_DN_RD;
        end
        S_DN_RD: state <= S_DN_CMP;
        S_DN_CMP: begin
          if (has_l && dn_swap) begin
            pos   <= pick_a;
            state <= S_DN_RD;
          end else begin
            state <= S_RT_RD;
          end
        end
        S_RT_RD: state <= S_RT_CMP;
        S_RT_CMP: begin
          ready_res <= (count != '0) && (rda[KEY_BITS-1:0] <= now_q);
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the final level write of a sift lands in the cycle before the root read

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY)) else $error("count above capacity");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("result while working");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    done && popped_valid |-> status == mheq_pkg::ST_OK)
    else $error("pop flagged with error");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(state == S_IDLE) |-> $stable(count)) else $error("count moved mid sift");

endmodule

@@ rtl/mheq_store.sv @@
// ----------------------------------------------------------------------------
// mheq_store: heap entry memory
// One write port and two registered read ports, entries of key and payload.
// ----------------------------------------------------------------------------
module mheq_store #(
  parameter int CAPACITY = mheq_pkg::CAPACITY_DEF,
  parameter int WIDTH    = 80
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [$clog2(CAPACITY)-1:0] waddr,
  input  logic [WIDTH-1:0]            wdata,
  input  logic [$clog2(CAPACITY)-1:0] raddr_a,
  input  logic [$clog2(CAPACITY)-1:0] raddr_b,
  output logic [WIDTH-1:0]            rdata_a,
  output logic [WIDTH-1:0]            rdata_b
);

  logic [WIDTH-1:0] mem [CAPACITY];

  // write, then registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ bench/min_heap_event_queue_top_tb.sv @@
// ----------------------------------------------------------------------------
// min_heap_event_queue_top_tb: self-checking bench of the min-heap event queue
// Drives insert, pop and status requests with random gaps, predicts each
// result with a behavioral heap and compares every strobed result in order.
// ----------------------------------------------------------------------------
module min_heap_event_queue_top_tb;

  localparam int CAP      = mheq_pkg::CAPACITY_DEF;
  localparam int KB       = mheq_pkg::KEY_BITS_DEF;
  localparam int CB       = mheq_pkg::COORD_BITS_DEF;
  localparam int OCC_BITS = $clog2(CAP + 1);
  localparam int NUM_RAND = 1100;
  localparam int WD_LIMIT = 20000;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic          pv;
    logic [KB-1:0] om;
    logic [CB-1:0] ox;
    logic [CB-1:0] oy;
    logic [1:0]    st;
    logic [OCC_BITS-1:0] occ;
    logic          rdy;
  } heap_result_t;

  int error_count = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Behavioral heap; keeps its own copy of the event store.
  class heap_scoreboard;
    logic [KB-1:0]   keys[CAP];
    logic [2*CB-1:0] pay[CAP];
    int              count;
    heap_result_t    pending[$];

    function void swap_entries(int a, int b);
      logic [KB-1:0]   k;
      logic [2*CB-1:0] p;
      k = keys[a]; p = pay[a];
      keys[a] = keys[b]; pay[a] = pay[b];
      keys[b] = k; pay[b] = p;
    endfunction

    function void note_request(logic [1:0] m, logic [KB-1:0] key, logic [CB-1:0] x,
                               logic [CB-1:0] y, logic [KB-1:0] tnow);
      heap_result_t r;
      int pos, par, l, rt, pick;
      r = '0;
      if (m == mheq_pkg::MODE_INSERT) begin
        if (count >= CAP) begin
          r.st = mheq_pkg::ST_FULL;
        end else begin
          keys[count] = key;
          pay[count] = {y, x};
          pos = count;
          count++;
          // sift up on strictly greater parent
          while (pos > 0) begin
            par = (pos - 1) / 2;
            if (keys[par] > keys[pos]) begin
              swap_entries(par, pos);
              pos = par;
            end else break;
          end
        end
      end else if (m == mheq_pkg::MODE_POP) begin
        if (count == 0) begin
          r.st = mheq_pkg::ST_EMPTY;
        end else begin
          r.pv = 1'b1;
          r.om = keys[0];
          {r.oy, r.ox} = pay[0];
          count--;
          keys[0] = keys[count];
          pay[0] = pay[count];
          pos = 0;
          // sift down; right child only when strictly smaller
          forever begin
            l = 2 * pos + 1;
            rt = l + 1;
            if (l >= count) break;
            pick = l;
            if (rt < count && keys[l] > keys[rt]) pick = rt;
            if (keys[pos] > keys[pick]) begin
              swap_entries(pos, pick);
              pos = pick;
            end else break;
          end
        end
      end
      r.occ = OCC_BITS'(count);
      r.rdy = (count > 0) && (keys[0] <= tnow);
      pending.push_back(r);
    endfunction

    task check_result(heap_result_t got);
      heap_result_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", 64'd0, 64'd0);
        return;
      end
      w = pending.pop_front();
      if (got.pv !== w.pv) report_mismatch("popped_valid", 64'(got.pv), 64'(w.pv));
      if (got.om !== w.om) report_mismatch("out_moment", 64'(got.om), 64'(w.om));
      if (got.ox !== w.ox) report_mismatch("out_x", 64'(got.ox), 64'(w.ox));
      if (got.oy !== w.oy) report_mismatch("out_y", 64'(got.oy), 64'(w.oy));
      if (got.st !== w.st) report_mismatch("status", 64'(got.st), 64'(w.st));
      if (got.occ !== w.occ) report_mismatch("occupancy", 64'(got.occ), 64'(w.occ));
      if (got.rdy !== w.rdy) report_mismatch("ready_res", 64'(got.rdy), 64'(w.rdy));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] mode = MODE_QUERY;
  logic [KB-1:0] event_moment = '0;
  logic [CB-1:0] event_x = '0;
  logic [CB-1:0] event_y = '0;
  logic [KB-1:0] now = '0;
  logic busy, done, popped_valid, ready_res;
  logic [KB-1:0] out_moment;
  logic [CB-1:0] out_x, out_y;
  logic [1:0] status;
  logic [OCC_BITS-1:0] occupancy;

  heap_scoreboard sb = new();
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  min_heap_event_queue_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .event_moment(event_moment), .event_x(event_x), .event_y(event_y), .now(now),
    .done(done), .popped_valid(popped_valid), .out_moment(out_moment),
    .out_x(out_x), .out_y(out_y), .status(status), .occupancy(occupancy),
    .ready_res(ready_res)
  );

  // Check each strobed result; watch for a stuck block.
  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        sb.check_result({popped_valid, out_moment, out_x, out_y, status,
                         occupancy, ready_res});
      if (done || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic logic [KB-1:0] rand_key();
    case ($urandom_range(0, 5))
      0: rand_key = '0;
      1: rand_key = '1;
      2: rand_key = KB'($urandom_range(0, 7));
      default: rand_key = KB'({$urandom(), $urandom()});
    endcase
  endfunction

  // Hold a random gap, mostly short with a few long ones.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk);
  endtask

  // Issue one request, hold it until accepted, then drop start again.
  task automatic send_request(input logic [1:0] m, input logic [KB-1:0] key,
                              input logic [CB-1:0] x, input logic [CB-1:0] y,
                              input logic [KB-1:0] tnow);
    start <= 1'b1;
    mode <= m;
    event_moment <= key;
    event_x <= x;
    event_y <= y;
    now <= tnow;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(m, key, x, y, tnow);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random(input logic [1:0] m);
    send_request(m, rand_key(), CB'($urandom()), CB'($urandom()),
                 ($urandom_range(0, 3) == 0) ? '1 : rand_key());
  endtask

  task automatic wait_drain();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int i, phase, target;
    logic [1:0] m;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty pop, extremes, ties, unused mode, full heap.
    send_request(mheq_pkg::MODE_POP, '0, '0, '0, '1);
    send_request(MODE_QUERY, '1, '1, '1, '1);
    send_request(mheq_pkg::MODE_INSERT, '1, '1, '1, '0);
    send_request(mheq_pkg::MODE_INSERT, '1, 16'h1234, 16'h5678, '1);
    send_request(mheq_pkg::MODE_INSERT, '0, '0, '0, '0);
    send_request(mheq_pkg::MODE_INSERT, 48'd5, 16'haaaa, 16'h5555, 48'd4);
    send_request(mheq_pkg::MODE_INSERT, 48'd5, 16'h5555, 16'haaaa, 48'd5);
    send_request(MODE_UNUSED, '1, '1, '1, '1);
    repeat (5) send_request(mheq_pkg::MODE_POP, '1, '1, '1, '1);
    send_request(mheq_pkg::MODE_POP, '0, '0, '0, '0);
    for (i = 0; i < CAP + 2; i++)
      send_request(mheq_pkg::MODE_INSERT, 48'd3, CB'(i), CB'(~i), 48'd3);
    wait_drain();
    for (i = 0; i < CAP + 1; i++) send_random(mheq_pkg::MODE_POP);

    // Random phases, each biased toward filling, draining or mixing.
    for (phase = 0; phase < 10; phase++) begin
      for (i = 0; i < NUM_RAND / 10; i++) begin
        target = $urandom_range(0, 99);
        case (phase % 3)
          0: m = (target < 70) ? mheq_pkg::MODE_INSERT :
                 (target < 90) ? mheq_pkg::MODE_POP : MODE_QUERY;
          1: m = (target < 25) ? mheq_pkg::MODE_INSERT :
                 (target < 90) ? mheq_pkg::MODE_POP : MODE_UNUSED;
          default: m = (target < 48) ? mheq_pkg::MODE_INSERT :
                       (target < 96) ? mheq_pkg::MODE_POP : MODE_QUERY;
        endcase
        send_random(m);
        if (phase % 2 == 0) idle_gap();
      end
      // Pause until every expected result has come.
      wait_drain();
    end

    wait_drain();
    repeat (40) @(posedge clk);
    if (error_count == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/mheq_pkg.sv
rtl/mheq_store.sv
rtl/min_heap_event_queue_top.sv
bench/min_heap_event_queue_top_tb.sv
